FILE: hw/rtl/ldf_pkg.sv
// Shared types, constants and the control store for the length-framed byte deframer.
package ldf_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 32;

  localparam logic [7:0] START_MARKER_RST = 8'hAC;
  localparam logic [7:0] END_MARKER_RST   = 8'hEF;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER   = 1'b1;

  typedef enum logic [2:0] {
    ST_DATA    = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_BADINV  = 3'd2,
    ST_BADEND  = 3'd3,
    ST_TOOLONG = 3'd4
  } frame_status_e;

  // Branch conditions tested by a step; a hit loads the step's target.
  typedef enum logic [3:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NOT_START,
    COND_TOO_LONG,
    COND_LEN_ZERO,
    COND_DATA_MORE,
    COND_INV_BAD,
    COND_END_BAD,
    COND_LAST
  } cond_e;

  localparam int unsigned PC_W = 5;

  // The replay steps follow the empty-frame test, which falls through into them.
  localparam logic [PC_W-1:0] PC_WAIT_START = 5'd0;
  localparam logic [PC_W-1:0] PC_TST_START  = 5'd1;
  localparam logic [PC_W-1:0] PC_WAIT_LEN   = 5'd2;
  localparam logic [PC_W-1:0] PC_TST_LEN    = 5'd3;
  localparam logic [PC_W-1:0] PC_TST_ZERO   = 5'd4;
  localparam logic [PC_W-1:0] PC_WAIT_DATA  = 5'd5;
  localparam logic [PC_W-1:0] PC_TST_DATA   = 5'd6;
  localparam logic [PC_W-1:0] PC_WAIT_CHK   = 5'd7;
  localparam logic [PC_W-1:0] PC_TST_CHK    = 5'd8;
  localparam logic [PC_W-1:0] PC_WAIT_END   = 5'd9;
  localparam logic [PC_W-1:0] PC_TST_END    = 5'd10;
  localparam logic [PC_W-1:0] PC_TST_EMPTY  = 5'd11;
  localparam logic [PC_W-1:0] PC_RD_FIRST   = 5'd12;
  localparam logic [PC_W-1:0] PC_EMIT_DATA  = 5'd13;
  localparam logic [PC_W-1:0] PC_RD_NEXT    = 5'd14;
  localparam logic [PC_W-1:0] PC_EMIT_LONG  = 5'd15;
  localparam logic [PC_W-1:0] PC_EMIT_INV   = 5'd16;
  localparam logic [PC_W-1:0] PC_EMIT_END   = 5'd17;
  localparam logic [PC_W-1:0] PC_EMIT_EMPTY = 5'd18;

  typedef struct packed {
    logic            wait_in;  // hold until an input beat, latch it
    cond_e           cond;
    logic [PC_W-1:0] target;
    logic            load_len;
    logic            clr_cnt;
    logic            inc_cnt;
    logic            wr_mem;
    logic            rd_mem;
    logic            emit;     // hold until the output register is free
    frame_status_e   status;
  } ctrl_word_t;

  localparam ctrl_word_t CW_NOP = '{
    wait_in:  1'b0,
    cond:     COND_NEVER,
    target:   PC_WAIT_START,
    load_len: 1'b0,
    clr_cnt:  1'b0,
    inc_cnt:  1'b0,
    wr_mem:   1'b0,
    rd_mem:   1'b0,
    emit:     1'b0,
    status:   ST_DATA
  };

  // Control store. A step with no hit advances to the next address.
  function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
    ctrl_word_t w;
    w = CW_NOP;
    unique case (pc)
      PC_WAIT_START, PC_WAIT_LEN, PC_WAIT_DATA, PC_WAIT_CHK, PC_WAIT_END: begin
        w.wait_in = 1'b1;
      end
      PC_TST_START: begin
        w.cond   = COND_NOT_START;
        w.target = PC_WAIT_START;
      end
      PC_TST_LEN: begin
        w.load_len = 1'b1;
        w.clr_cnt  = 1'b1;
        w.cond     = COND_TOO_LONG;
        w.target   = PC_EMIT_LONG;
      end
      PC_TST_ZERO: begin
        w.cond   = COND_LEN_ZERO;
        w.target = PC_WAIT_CHK;
      end
      PC_TST_DATA: begin
        w.wr_mem  = 1'b1;
        w.inc_cnt = 1'b1;
        w.cond    = COND_DATA_MORE;
        w.target  = PC_WAIT_DATA;
      end
      PC_TST_CHK: begin
        w.cond   = COND_INV_BAD;
        w.target = PC_EMIT_INV;
      end
      PC_TST_END: begin
        w.cond   = COND_END_BAD;
        w.target = PC_EMIT_END;
      end
      PC_TST_EMPTY: begin
        w.clr_cnt = 1'b1;
        w.cond    = COND_LEN_ZERO;
        w.target  = PC_EMIT_EMPTY;
      end
      PC_EMIT_LONG: begin
        w.emit   = 1'b1;
        w.status = ST_TOOLONG;
        w.cond   = COND_ALWAYS;
      end
      PC_EMIT_INV: begin
        w.emit   = 1'b1;
        w.status = ST_BADINV;
        w.cond   = COND_ALWAYS;
      end
      PC_EMIT_END: begin
        w.emit   = 1'b1;
        w.status = ST_BADEND;
        w.cond   = COND_ALWAYS;
      end
      PC_EMIT_EMPTY: begin
        w.emit   = 1'b1;
        w.status = ST_EMPTY;
        w.cond   = COND_ALWAYS;
      end
      PC_RD_FIRST: begin
        w.rd_mem = 1'b1;
      end
      PC_EMIT_DATA: begin
        w.emit    = 1'b1;
        w.status  = ST_DATA;
        w.inc_cnt = 1'b1;
        w.cond    = COND_LAST;
        w.target  = PC_WAIT_START;
      end
      PC_RD_NEXT: begin
        w.rd_mem = 1'b1;
        w.cond   = COND_ALWAYS;
        w.target = PC_EMIT_DATA;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = PC_WAIT_START;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: hw/rtl/ldf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ldf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/ldf_useq.sv
// Step counter and control store lookup for the deframer sequencer.
module ldf_useq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               go_i,   // current step completes this cycle
  input  logic               hit_i,  // its branch condition holds
  output ldf_pkg::ctrl_word_t ctrl_o
);

  logic [ldf_pkg::PC_W-1:0] pc_q, pc_d;
  ldf_pkg::ctrl_word_t      ctrl;

  assign ctrl   = ldf_pkg::ucode(pc_q);
  assign ctrl_o = ctrl;

  always_comb begin
    pc_d = pc_q;
    if (go_i) begin
      pc_d = hit_i ? ctrl.target : pc_q + ldf_pkg::PC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= ldf_pkg::PC_WAIT_START;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

FILE: hw/rtl/length_framed_byte_deframer.sv
// Top level of the length-framed byte deframer: datapath around a microcoded sequencer.
//
//   channel   direction  handshake                payload
//   in        sink       in_valid_i / in_stall_o  rx_byte_i
//   out       source     out_valid_o / out_stall_i payload_byte_o, frame_length_o,
//                                                  frame_status_o, last_of_run_o
//   cfg       sink       cfg_we_i                 cfg_addr_i, cfg_wdata_i
//
// The sequencer runs one control step per cycle unless it waits for an input byte
// or a free output slot. A byte outside a frame, a payload byte and an inverted-length
// byte pass an accept and a test step; the length and end bytes add a zero-length or
// empty-frame test. A good frame replays each beat as a read step, then an emit step.
// Reset clears the step counter, counters and output valid; the markers return to
// 0xAC and 0xEF. The payload buffer needs no clearing: only bytes of the current
// frame are ever read back.
// A stalled output holds the emitting step, and input stays stalled until the
// sequencer comes back to a step that waits for a byte.
module length_framed_byte_deframer #(
  parameter int unsigned MAX_PAYLOAD = ldf_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input bytes
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    rx_byte_i,
  // result beats
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    payload_byte_o,
  output logic [7:0]                    frame_length_o,
  output logic [2:0]                    frame_status_o,
  output logic                          last_of_run_o,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [ldf_pkg::CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [7:0]                    cfg_wdata_i
);

  localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int unsigned CW = $clog2(MAX_PAYLOAD + 1);

  // Configuration registers
  logic [7:0] start_marker_q, end_marker_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_marker_q <= ldf_pkg::START_MARKER_RST;
      end_marker_q   <= ldf_pkg::END_MARKER_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        ldf_pkg::CFG_START_MARKER: start_marker_q <= cfg_wdata_i;
        ldf_pkg::CFG_END_MARKER:   end_marker_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Sequencer
  ldf_pkg::ctrl_word_t ctrl;
  logic                go, hit, out_free;

  ldf_useq u_useq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (go),
    .hit_i  (hit),
    .ctrl_o (ctrl)
  );

  // Datapath registers
  logic [7:0]    byte_q;
  logic [7:0]    len_q;
  logic [CW-1:0] cnt_q;
  logic [8:0]    cnt_inc;
  logic [8:0]    len_ext;
  logic [7:0]    rd_data;

  assign cnt_inc = 9'(cnt_q) + 9'd1;
  assign len_ext = {1'b0, len_q};

  assign out_free   = !out_valid_o || !out_stall_i;
  assign in_stall_o = !ctrl.wait_in;

  // A waiting step advances on an input beat, an emitting step on a free output slot.
  always_comb begin
    if (ctrl.wait_in) begin
      go = in_valid_i;
    end else if (ctrl.emit) begin
      go = out_free;
    end else begin
      go = 1'b1;
    end
  end

  always_comb begin
    unique case (ctrl.cond)
      ldf_pkg::COND_NEVER:     hit = 1'b0;
      ldf_pkg::COND_ALWAYS:    hit = 1'b1;
      ldf_pkg::COND_NOT_START: hit = (byte_q != start_marker_q);
      ldf_pkg::COND_TOO_LONG:  hit = (byte_q > 8'(MAX_PAYLOAD));
      ldf_pkg::COND_LEN_ZERO:  hit = (len_q == 8'd0);
      ldf_pkg::COND_DATA_MORE: hit = (cnt_inc < len_ext);
      ldf_pkg::COND_INV_BAD:   hit = (byte_q != ~len_q);
      ldf_pkg::COND_END_BAD:   hit = (byte_q != end_marker_q);
      ldf_pkg::COND_LAST:      hit = (cnt_inc == len_ext);
      default:                 hit = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= 8'd0;
      len_q  <= 8'd0;
      cnt_q  <= '0;
    end else if (go) begin
      if (ctrl.wait_in) begin
        byte_q <= rx_byte_i;
      end
      if (ctrl.load_len) begin
        len_q <= byte_q;
      end
      if (ctrl.clr_cnt) begin
        cnt_q <= '0;
      end else if (ctrl.inc_cnt) begin
        cnt_q <= cnt_q + CW'(1);
      end
    end
  end

  // Payload buffer: written in arrival order, replayed from entry zero.
  ldf_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PAYLOAD)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (go && ctrl.wr_mem),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (byte_q),
    .re_i    (go && ctrl.rd_mem),
    .raddr_i (cnt_q[AW-1:0]),
    .rdata_o (rd_data)
  );

  // Output register: load on an emitting step, drop once the beat is taken.
  logic       out_valid_q;
  logic [7:0] payload_q, flen_q;
  logic [2:0] status_q;
  logic       last_q;
  logic       is_data;

  assign is_data = (ctrl.status == ldf_pkg::ST_DATA);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (go && ctrl.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && ctrl.emit) begin
      payload_q <= is_data ? rd_data : 8'd0;
      flen_q    <= len_q;
      status_q  <= ctrl.status;
      last_q    <= is_data ? (cnt_inc == len_ext) : 1'b1;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign payload_byte_o = payload_q;
  assign frame_length_o = flen_q;
  assign frame_status_o = status_q;
  assign last_of_run_o  = last_q;

endmodule

FILE: hw/rtl/ldf_checker.sv
// Port-level checks for the deframer, bound to its top level.
module ldf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] payload_byte_o,
  input logic [7:0] frame_length_o,
  input logic [2:0] frame_status_o,
  input logic       last_of_run_o
);

  // A stalled result beat holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(out_valid_o && out_stall_i) |->
      out_valid_o && $stable(payload_byte_o) && $stable(frame_length_o)
      && $stable(frame_status_o) && $stable(last_of_run_o))
    else $error("result beat changed while stalled");

  // Every byte is tested in the cycle after it is taken, so input is stalled in that cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken in back-to-back cycles");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_status_o != ldf_pkg::ST_DATA) |->
      (payload_byte_o == 8'd0 && last_of_run_o))
    else $error("status beat with data or without last flag");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_status_o == ldf_pkg::ST_DATA) |-> (frame_length_o != 8'd0))
    else $error("payload beat from an empty frame");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_status_o == ldf_pkg::ST_EMPTY) |-> (frame_length_o == 8'd0))
    else $error("empty-frame beat with nonzero length");

endmodule

bind length_framed_byte_deframer ldf_checker u_ldf_checker (.*);
